### sv/tcc_pkg.sv
`timescale 1ns / 1ps

package tcc_pkg;

    // Calendar origin
    localparam int EPOCH_YEAR   = 1601;
    localparam int BASE_WEEKDAY = 1;

    // Leap years in 1 .. EPOCH_YEAR-1
    localparam int LEAPS_BASE = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                              + (EPOCH_YEAR - 1) / 400;

    // Pipeline depth
    localparam int NUM_STAGES = 17;

    // Constant divisors and their exact reciprocals: q = (v * M) >> S
    localparam int C_SEC = 78125;   // 10^7 / 2^7
    localparam int S_SEC = 49;
    localparam logic [32:0] M_SEC = 33'(((64'd1 << S_SEC) + 64'(C_SEC) - 64'd1) / 64'(C_SEC));

    localparam int C_MS = 10000;
    localparam int S_MS = 38;
    localparam logic [24:0] M_MS = 25'(((64'd1 << S_MS) + 64'(C_MS) - 64'd1) / 64'(C_MS));

    localparam int C_DAY = 675;     // 86400 / 2^7
    localparam int S_DAY = 38;
    localparam logic [28:0] M_DAY = 29'(((64'd1 << S_DAY) + 64'(C_DAY) - 64'd1) / 64'(C_DAY));
    localparam int SEC_PER_DAY = 86400;

    localparam int C_HR = 3600;
    localparam int S_HR = 29;
    localparam logic [17:0] M_HR = 18'(((64'd1 << S_HR) + 64'(C_HR) - 64'd1) / 64'(C_HR));

    localparam int C_YR = 365;
    localparam int S_YR = 28;
    localparam logic [19:0] M_YR = 20'(((64'd1 << S_YR) + 64'(C_YR) - 64'd1) / 64'(C_YR));

    localparam int C_WK = 7;
    localparam int S_WK = 23;
    localparam logic [20:0] M_WK = 21'(((64'd1 << S_WK) + 64'(C_WK) - 64'd1) / 64'(C_WK));

    localparam int C_MIN = 60;
    localparam int S_MIN = 18;
    localparam logic [12:0] M_MIN = 13'(((64'd1 << S_MIN) + 64'(C_MIN) - 64'd1) / 64'(C_MIN));

    localparam int C_CEN = 100;
    localparam int S_CEN = 21;
    localparam logic [14:0] M_CEN = 15'(((64'd1 << S_CEN) + 64'(C_CEN) - 64'd1) / 64'(C_CEN));

    localparam int C_MON = 31;
    localparam int S_MON = 14;
    localparam logic [9:0] M_MON = 10'(((64'd1 << S_MON) + 64'(C_MON) - 64'd1) / 64'(C_MON));

    // Days before the first of each month, non-leap year
    localparam logic [8:0] MONTH_START [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // Time-of-day fields carried down the pipeline
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] millisecond;
        logic [2:0] weekday;
    } tcc_tod_t;

endpackage

### sv/tick_count_to_calendar_unit.sv
`timescale 1ns / 1ps
// An accepted input item moves through the stage registers to its result on the master side.
// Throughput: one item per cycle while the output is free; the stages are reciprocal multiplies,
// remainder steps and calendar corrections, and the whole pipeline advances together.
// Reset: rst_n clears the stage valid bits only; payload registers are not reset.

module tick_count_to_calendar_unit
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [57:0] ticks
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata     // [11:0] year, [15:12] month, [20:16] day,
                                    // [25:21] hour, [31:26] minute, [37:32] second,
                                    // [47:38] millisecond, [50:48] weekday
);

    logic                  adv;
    logic [NUM_STAGES-1:0] vld_reg;

    // Stage registers
    logic [20:0] s1_v_reg;
    logic [53:0] s1_p_reg;
    logic [14:0] s1_mid_reg, s1_low_reg;
    logic [6:0]  s1_lo7_reg;

    logic [4:0]  s2_qa_reg;
    logic [31:0] s2_v_reg;
    logic [14:0] s2_low_reg;
    logic [6:0]  s2_lo7_reg;

    logic [64:0] s3_p_reg;
    logic [31:0] s3_v_reg;
    logic [4:0]  s3_qa_reg;
    logic [14:0] s3_low_reg;
    logic [6:0]  s3_lo7_reg;

    logic [31:0] s4_v_reg;
    logic [4:0]  s4_qa_reg;
    logic [14:0] s4_qb_reg;
    logic [6:0]  s4_lo7_reg;

    logic [64:0] s5_p_reg;
    logic [31:0] s5_v_reg;
    logic [4:0]  s5_qa_reg;
    logic [14:0] s5_qb_reg;
    logic [6:0]  s5_lo7_reg;

    logic [34:0] s6_secs_reg;
    logic [23:0] s6_sub_reg;

    logic [48:0] s7_pms_reg;
    logic [56:0] s7_pday_reg;
    logic [16:0] s7_slo_reg;

    logic [9:0]  s8_ms_reg;
    logic [18:0] s8_days_reg;
    logic [16:0] s8_sod_reg;

    logic [34:0] s9_phr_reg;
    logic [38:0] s9_pyr_reg;
    logic [40:0] s9_pwk_reg;
    logic [16:0] s9_sod_reg;
    logic [18:0] s9_days_reg;
    logic [9:0]  s9_ms_reg;
    logic [19:0] s9_wdv_reg;

    logic [4:0]  s10_hour_reg;
    logic [11:0] s10_remh_reg;
    logic [9:0]  s10_ye_reg;
    logic [2:0]  s10_wd_reg;
    logic [18:0] s10_days_reg;
    logic [9:0]  s10_ms_reg;

    logic [24:0] s11_pmin_reg;
    logic [28:0] s11_pcen_reg;
    logic [11:0] s11_remh_reg;
    logic [9:0]  s11_ye_reg;
    logic [13:0] s11_n_reg;
    logic [4:0]  s11_hour_reg;
    logic [2:0]  s11_wd_reg;
    logic [18:0] s11_days_reg;
    logic [9:0]  s11_ms_reg;

    logic [9:0]  s12_ye_reg;
    logic [1:0]  s12_n_reg;
    logic [1:0]  s12_c_reg;
    logic [6:0]  s12_m_reg;
    logic [19:0] s12_ytd_reg;
    logic [18:0] s12_days_reg;
    tcc_tod_t    s12_tod_reg;

    logic [19:0] s13_ytd_reg;
    logic [13:0] s13_year_reg;
    logic        s13_leap_reg;
    logic [18:0] s13_days_reg;
    tcc_tod_t    s13_tod_reg;

    logic [8:0]  s14_doy_reg;
    logic [13:0] s14_year_reg;
    logic        s14_leap_reg;
    tcc_tod_t    s14_tod_reg;

    logic [18:0] s15_p_reg;
    logic [8:0]  s15_doy_reg;
    logic [13:0] s15_year_reg;
    logic        s15_leap_reg;
    tcc_tod_t    s15_tod_reg;

    logic [3:0]  s16_mon_reg;
    logic [9:0]  s16_mtd_reg;
    logic [8:0]  s16_doy_reg;
    logic [13:0] s16_year_reg;
    logic        s16_leap_reg;
    tcc_tod_t    s16_tod_reg;

    logic [3:0]  s17_mon_reg;
    logic [4:0]  s17_dom_reg;
    logic [11:0] s17_year_reg;
    tcc_tod_t    s17_tod_reg;

    // Next values
    logic [20:0] s1_v_next;
    logic [53:0] s1_p_next;
    logic [4:0]  s2_qa_next;
    logic [16:0] s2_r;
    logic [31:0] s2_v_next;
    logic [64:0] s3_p_next;
    logic [14:0] s4_qb_next;
    logic [16:0] s4_r;
    logic [31:0] s4_v_next;
    logic [64:0] s5_p_next;
    logic [14:0] s6_qc;
    logic [16:0] s6_r;
    logic [34:0] s6_secs_next;
    logic [23:0] s6_sub_next;
    logic [48:0] s7_pms_next;
    logic [56:0] s7_pday_next;
    logic [18:0] s8_days_next;
    logic [16:0] s8_sod_next;
    logic [34:0] s9_phr_next;
    logic [38:0] s9_pyr_next;
    logic [19:0] s9_wdv_next;
    logic [40:0] s9_pwk_next;
    logic [4:0]  s10_hour_next;
    logic [11:0] s10_remh_next;
    logic [15:0] s10_q7;
    logic [2:0]  s10_wd_next;
    logic [24:0] s11_pmin_next;
    logic [13:0] s11_n_next;
    logic [28:0] s11_pcen_next;
    logic [5:0]  s12_min;
    logic [5:0]  s12_sec;
    logic [7:0]  s12_c100;
    logic [6:0]  s12_m_next;
    logic [19:0] s12_ytd_next;
    logic        s13_leap_n, s13_leap_y, s13_dec;
    logic [6:0]  s13_my;
    logic [1:0]  s13_cy;
    logic [19:0] s13_ytd_next;
    logic [8:0]  s14_doy_next;
    logic [18:0] s15_p_next;
    logic [3:0]  s16_q;
    logic [3:0]  s16_mon_next;
    logic [9:0]  s16_mtd_next;
    logic        s17_inc;
    logic [3:0]  s17_mon_next;
    logic [9:0]  s17_start;
    logic [4:0]  s17_dom_next;

    // Advance the whole pipeline unless the output is held
    assign adv      = !vld_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = adv;

    // Seconds division, top chunk of ticks >> 7
    assign s1_v_next = s_tdata[57:37];
    assign s1_p_next = 54'(s1_v_next) * 54'(M_SEC);

    assign s2_qa_next = s1_p_reg[53:49];
    assign s2_r       = 17'(s1_v_reg - 21'(21'(s2_qa_next) * 21'(C_SEC)));
    assign s2_v_next  = {s2_r, s1_mid_reg};

    assign s3_p_next = 65'(s2_v_reg) * 65'(M_SEC);

    assign s4_qb_next = s3_p_reg[63:49];
    assign s4_r       = 17'(s3_v_reg - 32'(32'(s4_qb_next) * 32'(C_SEC)));
    assign s4_v_next  = {s4_r, s3_low_reg};

    assign s5_p_next = 65'(s4_v_reg) * 65'(M_SEC);

    // Whole seconds and the leftover ticks within the second
    assign s6_qc        = s5_p_reg[63:49];
    assign s6_r         = 17'(s5_v_reg - 32'(32'(s6_qc) * 32'(C_SEC)));
    assign s6_secs_next = {s5_qa_reg, s5_qb_reg, s6_qc};
    assign s6_sub_next  = {s6_r, s5_lo7_reg};

    // Milliseconds and days
    assign s7_pms_next  = 49'(s6_sub_reg) * 49'(M_MS);
    assign s7_pday_next = 57'(s6_secs_reg[34:7]) * 57'(M_DAY);

    assign s8_days_next = s7_pday_reg[56:38];
    assign s8_sod_next  = 17'(s7_slo_reg - 17'(37'(s8_days_next) * 37'(SEC_PER_DAY)));

    // Hour, year estimate and weekday
    assign s9_phr_next = 35'(s8_sod_reg) * 35'(M_HR);
    assign s9_pyr_next = 39'(s8_days_reg) * 39'(M_YR);
    assign s9_wdv_next = 20'(s8_days_reg) + 20'(BASE_WEEKDAY);
    assign s9_pwk_next = 41'(s9_wdv_next) * 41'(M_WK);

    assign s10_hour_next = s9_phr_reg[33:29];
    assign s10_remh_next = 12'(s9_sod_reg - 17'(17'(s10_hour_next) * 17'(C_HR)));
    assign s10_q7        = s9_pwk_reg[38:23];
    assign s10_wd_next   = 3'(s9_wdv_reg - 20'(20'(s10_q7) * 20'(C_WK)));

    // Minute and century count of the year before the estimate
    assign s11_pmin_next = 25'(s10_remh_reg) * 25'(M_MIN);
    assign s11_n_next    = 14'(14'(s10_ye_reg) + 14'(EPOCH_YEAR - 1));
    assign s11_pcen_next = 29'(s11_n_next) * 29'(M_CEN);

    // Days before the estimated year
    assign s12_min      = s11_pmin_reg[23:18];
    assign s12_sec      = 6'(s11_remh_reg - 12'(12'(s12_min) * 12'(C_MIN)));
    assign s12_c100     = s11_pcen_reg[28:21];
    assign s12_m_next   = 7'(s11_n_reg - 14'(14'(s12_c100) * 14'(C_CEN)));
    assign s12_ytd_next = 20'(21'(s11_ye_reg) * 21'(C_YR) + 21'(s11_n_reg >> 2)
                              - 21'(s12_c100) + 21'(s12_c100 >> 2) - 21'(LEAPS_BASE));

    // Correct the year by one where its start lies past the day count
    assign s13_leap_n   = ((s12_n_reg == 2'd0) && (s12_m_reg != 7'd0))
                        || ((s12_m_reg == 7'd0) && (s12_c_reg == 2'd0));
    assign s13_my       = (s12_m_reg == 7'd99) ? 7'd0 : 7'(s12_m_reg + 7'd1);
    assign s13_cy       = 2'(s12_c_reg + 2'((s12_m_reg == 7'd99) ? 1 : 0));
    assign s13_leap_y   = ((2'(s12_n_reg + 2'd1) == 2'd0) && (s13_my != 7'd0))
                        || ((s13_my == 7'd0) && (s13_cy == 2'd0));
    assign s13_dec      = s12_ytd_reg > 20'(s12_days_reg);
    assign s13_ytd_next = s13_dec
                        ? 20'(s12_ytd_reg - 20'(C_YR) - 20'(s13_leap_n))
                        : s12_ytd_reg;

    assign s14_doy_next = 9'(20'(s13_days_reg) - s13_ytd_reg);

    // Month estimate from the day of year
    assign s15_p_next = 19'(s14_doy_reg) * 19'(M_MON);

    assign s16_q        = s15_p_reg[17:14];
    assign s16_mon_next = (s16_q >= 4'd11) ? 4'd12 : 4'(s16_q + 4'd1);
    assign s16_mtd_next = 10'(MONTH_START[s16_mon_next])
                        + 10'((s15_leap_reg && (s16_mon_next >= 4'd2)) ? 1 : 0);

    // Raise the month by one at the next month's start, then the day of month
    assign s17_inc      = (10'(s16_doy_reg) >= s16_mtd_reg) && (s16_mon_reg < 4'd12);
    assign s17_mon_next = 4'(s16_mon_reg + 4'(s17_inc));
    assign s17_start    = 10'(MONTH_START[4'(s17_mon_next - 4'd1)])
                        + 10'((s16_leap_reg && (s17_mon_next > 4'd2)) ? 1 : 0);
    assign s17_dom_next = 5'(10'(s16_doy_reg) - s17_start + 10'd1);

    // Shift valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    // Move payload one stage on each advance
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_v_reg   <= s1_v_next;
            s1_p_reg   <= s1_p_next;
            s1_mid_reg <= s_tdata[36:22];
            s1_low_reg <= s_tdata[21:7];
            s1_lo7_reg <= s_tdata[6:0];

            s2_qa_reg  <= s2_qa_next;
            s2_v_reg   <= s2_v_next;
            s2_low_reg <= s1_low_reg;
            s2_lo7_reg <= s1_lo7_reg;

            s3_p_reg   <= s3_p_next;
            s3_v_reg   <= s2_v_reg;
            s3_qa_reg  <= s2_qa_reg;
            s3_low_reg <= s2_low_reg;
            s3_lo7_reg <= s2_lo7_reg;

            s4_v_reg   <= s4_v_next;
            s4_qa_reg  <= s3_qa_reg;
            s4_qb_reg  <= s4_qb_next;
            s4_lo7_reg <= s3_lo7_reg;

            s5_p_reg   <= s5_p_next;
            s5_v_reg   <= s4_v_reg;
            s5_qa_reg  <= s4_qa_reg;
            s5_qb_reg  <= s4_qb_reg;
            s5_lo7_reg <= s4_lo7_reg;

            s6_secs_reg <= s6_secs_next;
            s6_sub_reg  <= s6_sub_next;

            s7_pms_reg  <= s7_pms_next;
            s7_pday_reg <= s7_pday_next;
            s7_slo_reg  <= s6_secs_reg[16:0];

            s8_ms_reg   <= s7_pms_reg[47:38];
            s8_days_reg <= s8_days_next;
            s8_sod_reg  <= s8_sod_next;

            s9_phr_reg  <= s9_phr_next;
            s9_pyr_reg  <= s9_pyr_next;
            s9_pwk_reg  <= s9_pwk_next;
            s9_sod_reg  <= s8_sod_reg;
            s9_days_reg <= s8_days_reg;
            s9_ms_reg   <= s8_ms_reg;
            s9_wdv_reg  <= s9_wdv_next;

            s10_hour_reg <= s10_hour_next;
            s10_remh_reg <= s10_remh_next;
            s10_ye_reg   <= s9_pyr_reg[37:28];
            s10_wd_reg   <= s10_wd_next;
            s10_days_reg <= s9_days_reg;
            s10_ms_reg   <= s9_ms_reg;

            s11_pmin_reg <= s11_pmin_next;
            s11_pcen_reg <= s11_pcen_next;
            s11_remh_reg <= s10_remh_reg;
            s11_ye_reg   <= s10_ye_reg;
            s11_n_reg    <= s11_n_next;
            s11_hour_reg <= s10_hour_reg;
            s11_wd_reg   <= s10_wd_reg;
            s11_days_reg <= s10_days_reg;
            s11_ms_reg   <= s10_ms_reg;

            s12_ye_reg               <= s11_ye_reg;
            s12_n_reg                <= s11_n_reg[1:0];
            s12_c_reg                <= s12_c100[1:0];
            s12_m_reg                <= s12_m_next;
            s12_ytd_reg              <= s12_ytd_next;
            s12_days_reg             <= s11_days_reg;
            s12_tod_reg.hour         <= s11_hour_reg;
            s12_tod_reg.minute       <= s12_min;
            s12_tod_reg.second       <= s12_sec;
            s12_tod_reg.millisecond  <= s11_ms_reg;
            s12_tod_reg.weekday      <= s11_wd_reg;

            s13_ytd_reg  <= s13_ytd_next;
            s13_year_reg <= 14'(14'(s12_ye_reg) + 14'(EPOCH_YEAR) - 14'(s13_dec));
            s13_leap_reg <= s13_dec ? s13_leap_n : s13_leap_y;
            s13_days_reg <= s12_days_reg;
            s13_tod_reg  <= s12_tod_reg;

            s14_doy_reg  <= s14_doy_next;
            s14_year_reg <= s13_year_reg;
            s14_leap_reg <= s13_leap_reg;
            s14_tod_reg  <= s13_tod_reg;

            s15_p_reg    <= s15_p_next;
            s15_doy_reg  <= s14_doy_reg;
            s15_year_reg <= s14_year_reg;
            s15_leap_reg <= s14_leap_reg;
            s15_tod_reg  <= s14_tod_reg;

            s16_mon_reg  <= s16_mon_next;
            s16_mtd_reg  <= s16_mtd_next;
            s16_doy_reg  <= s15_doy_reg;
            s16_year_reg <= s15_year_reg;
            s16_leap_reg <= s15_leap_reg;
            s16_tod_reg  <= s15_tod_reg;

            s17_mon_reg  <= s17_mon_next;
            s17_dom_reg  <= s17_dom_next;
            s17_year_reg <= s16_year_reg[11:0];
            s17_tod_reg  <= s16_tod_reg;
        end
    end

    // Pack the result item
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {5'd0, s17_tod_reg.weekday, s17_tod_reg.millisecond,
                       s17_tod_reg.second, s17_tod_reg.minute, s17_tod_reg.hour,
                       s17_dom_reg, s17_mon_reg, s17_year_reg};

`ifndef ASSERT_OFF
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (s17_mon_reg >= 4'd1) && (s17_mon_reg <= 4'd12)
                     && (s17_dom_reg >= 5'd1))
        else $error("month or day out of range");

    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (s17_tod_reg.hour < 5'd24) && (s17_tod_reg.minute < 6'd60)
                     && (s17_tod_reg.second < 6'd60)
                     && (s17_tod_reg.millisecond < 10'd1000)
                     && (s17_tod_reg.weekday < 3'd7))
        else $error("time of day or weekday out of range");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while held");
`endif

endmodule
